// ===== rtl/ebml_pkg.sv =====
// Shared types and constants for the EBML element header decoder.
// Holds the operation record passed from the front end to the back end.
// No dependencies.
package ebml_pkg;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_ID   = 2'd1;
  localparam logic [1:0] STATUS_BAD_SIZE = 2'd2;

  localparam logic [7:0] LEAD_UNKNOWN = 8'hFF;
  localparam logic [7:0] LEAD_MARK    = 8'h80;

  typedef struct packed {
    logic [7:0] byte_val;
    logic [3:0] field_len;
    logic       first;
    logic       is_size;
    logic       last;
    logic       err_id;
    logic       err_size;
    logic       unknown;
  } ebml_op_t;

endpackage

// ===== rtl/ebml_front.sv =====
// Front end: tracks field boundaries and classifies each header byte.
// Produces one ebml_op_t per accepted byte; uses ebml_pkg.
module ebml_front import ebml_pkg::*; #(
  parameter int unsigned MAX_VINT_BYTES = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] byte_in,
  output ebml_op_t   op
);

  logic       in_size_r, in_size_nxt;
  logic [3:0] bytes_left_r, bytes_left_nxt;
  logic [3:0] field_len_r, field_len_nxt;
  logic [3:0] lead_len;
  logic       lead_bad;

  always_comb begin
    lead_len = 4'd0;
    for (int i = 7; i >= 0; i--) begin
      if (lead_len == 4'd0 && (byte_in & (LEAD_MARK >> (7 - i))) != 8'd0) begin
        lead_len = 4'(8 - i);
      end
    end
  end

  assign lead_bad = (lead_len == 4'd0) || (lead_len > 4'(MAX_VINT_BYTES));

  always_comb begin
    op             = '0;
    op.byte_val    = byte_in;
    op.is_size     = in_size_r;
    in_size_nxt    = in_size_r;
    bytes_left_nxt = bytes_left_r;
    field_len_nxt  = field_len_r;
    if (bytes_left_r != 4'd0) begin
      op.field_len   = field_len_r;
      op.last        = (bytes_left_r == 4'd1);
      bytes_left_nxt = bytes_left_r - 4'd1;
      if (op.last) begin
        in_size_nxt = !in_size_r;
      end
    end else if (in_size_r && byte_in == LEAD_UNKNOWN) begin
      op.unknown  = 1'b1;
      in_size_nxt = 1'b0;
    end else if (lead_bad) begin
      op.err_size = in_size_r;
      op.err_id   = !in_size_r;
      in_size_nxt = 1'b0;
    end else begin
      op.first       = 1'b1;
      op.field_len   = lead_len;
      op.last        = (lead_len == 4'd1);
      if (in_size_r) begin
        op.byte_val = byte_in & (8'hFF >> lead_len);
      end
      field_len_nxt  = lead_len;
      bytes_left_nxt = lead_len - 4'd1;
      if (op.last) begin
        in_size_nxt = !in_size_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_size_r    <= 1'b0;
      bytes_left_r <= 4'd0;
      field_len_r  <= 4'd0;
    end else if (accept) begin
      in_size_r    <= in_size_nxt;
      bytes_left_r <= bytes_left_nxt;
      field_len_r  <= field_len_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    bytes_left_r < 4'(MAX_VINT_BYTES))
    else $error("bytes_left exceeds field length limit");

endmodule

// ===== rtl/ebml_op_fifo.sv =====
// Short queue of ebml_op_t records between the front end and the back end.
// Register-based, FIFO_DEPTH entries; uses ebml_pkg.
module ebml_op_fifo import ebml_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ebml_op_t push_op,
  output logic     full,
  input  logic     pop,
  output ebml_op_t pop_op,
  output logic     not_empty
);

  ebml_op_t                mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_PTR_W:0]     count_r, count_nxt;

  assign full      = (count_r == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_op    = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FIFO_PTR_W+1)'(FIFO_DEPTH))
    else $error("queue count out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    (pop |-> not_empty) and (push |-> (!full || pop)))
    else $error("queue overflow or underflow");

endmodule

// ===== rtl/ebml_back.sv =====
// Back end: builds field values from queued ops and drives the result register.
// Consumes ebml_op_t records; uses ebml_pkg.
module ebml_back import ebml_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        op_valid,
  input  ebml_op_t    op,
  output logic        op_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_element_id,
  output logic [3:0]  out_id_length,
  output logic [63:0] out_data_size,
  output logic        out_size_unknown,
  output logic [4:0]  out_header_length,
  output logic [1:0]  out_status
);

  logic [63:0] acc_r, acc_nxt;
  logic [63:0] held_id_r;
  logic [3:0]  held_len_r;
  logic        out_valid_r;
  logic [63:0] element_id_r, data_size_r;
  logic [3:0]  id_length_r;
  logic        size_unknown_r;
  logic [4:0]  header_length_r;
  logic [1:0]  status_r;
  logic        has_result;
  logic        load;

  assign acc_nxt    = op.first ? {56'd0, op.byte_val} : {acc_r[55:0], op.byte_val};
  assign has_result = op.err_id || op.err_size || op.unknown || (op.last && op.is_size);
  assign op_pop     = op_valid && (!has_result || !out_valid_r || out_ready);
  assign load       = op_pop && has_result;

  always_ff @(posedge clk) begin
    if (op_pop) begin
      acc_r <= acc_nxt;
      if (op.last && !op.is_size && !op.err_id && !op.err_size && !op.unknown) begin
        held_id_r  <= acc_nxt;
        held_len_r <= op.field_len;
      end
    end
    if (load) begin
      element_id_r    <= held_id_r;
      id_length_r     <= held_len_r;
      data_size_r     <= '0;
      size_unknown_r  <= 1'b0;
      header_length_r <= {1'b0, held_len_r} + 5'd1;
      status_r        <= STATUS_OK;
      if (op.err_id) begin
        element_id_r    <= '0;
        id_length_r     <= '0;
        header_length_r <= '0;
        status_r        <= STATUS_BAD_ID;
      end else if (op.err_size) begin
        status_r <= STATUS_BAD_SIZE;
      end else if (op.unknown) begin
        data_size_r    <= '1;
        size_unknown_r <= 1'b1;
      end else begin
        data_size_r     <= acc_nxt;
        header_length_r <= {1'b0, held_len_r} + {1'b0, op.field_len};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_element_id    = element_id_r;
  assign out_id_length     = id_length_r;
  assign out_data_size     = data_size_r;
  assign out_size_unknown  = size_unknown_r;
  assign out_header_length = header_length_r;
  assign out_status        = status_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before transfer");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(element_id_r) && $stable(data_size_r))
    else $error("pending result changed");

endmodule

// ===== rtl/ebml_element_header_decoder.sv =====
// EBML element header decoder top level: front end, op queue, back end.
// Throughput: one header byte per cycle sustained while the output is not stalled; input and
// output stalls are decoupled. The final byte's op is written into the op queue, and the
// result is then loaded from it into the result register once that register is free.
// The two-entry op queue and the result register set the decoupling depth.
// Reset (rst_n, synchronous, active low) clears parse state, queue and result valid.
// Depends on ebml_pkg, ebml_front, ebml_op_fifo and ebml_back.
module ebml_element_header_decoder import ebml_pkg::*; #(
  parameter int unsigned MAX_VINT_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_element_id,
  output logic [3:0]  out_id_length,
  output logic [63:0] out_data_size,
  output logic        out_size_unknown,
  output logic [4:0]  out_header_length,
  output logic [1:0]  out_status
);

  ebml_op_t front_op;
  ebml_op_t back_op;
  logic     fifo_full;
  logic     fifo_not_empty;
  logic     fifo_pop;
  logic     accept;

  assign in_ready = !fifo_full;
  assign accept   = in_valid && in_ready;

  ebml_front #(
    .MAX_VINT_BYTES(MAX_VINT_BYTES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .byte_in(in_byte_in),
    .op     (front_op)
  );

  ebml_op_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_op  (front_op),
    .full     (fifo_full),
    .pop      (fifo_pop),
    .pop_op   (back_op),
    .not_empty(fifo_not_empty)
  );

  ebml_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .op_valid         (fifo_not_empty),
    .op               (back_op),
    .op_pop           (fifo_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_element_id   (out_element_id),
    .out_id_length    (out_id_length),
    .out_data_size    (out_data_size),
    .out_size_unknown (out_size_unknown),
    .out_header_length(out_header_length),
    .out_status       (out_status)
  );

endmodule
